[sv/cps_pkg.sv]
package cps_pkg;

	// Timer width; timers saturate at all ones
	localparam int TimerBits = 16;
	// Width used to compare timers against 16-bit limits
	localparam int CmpW      = (TimerBits > 16) ? TimerBits : 16;

	// Configuration port geometry
	localparam int CfgIdxW  = 3;
	localparam int CfgDataW = 16;

	typedef logic [CfgIdxW-1:0] cfg_idx_t;

	localparam cfg_idx_t REG_STEP_MS           = 3'd0;
	localparam cfg_idx_t REG_STARTUP_MS        = 3'd1;
	localparam cfg_idx_t REG_PRECHARGE_MS      = 3'd2;
	localparam cfg_idx_t REG_VOLT_DELTA_LIMIT  = 3'd3;
	localparam cfg_idx_t REG_CHARGE_FRESH_MS   = 3'd4;
	localparam cfg_idx_t REG_CHARGE_TIMEOUT_MS = 3'd5;

	// Vehicle mode codes
	typedef logic [3:0] mode_t;

	localparam mode_t MODE_STARTUP  = 4'd0;
	localparam mode_t MODE_SDOPEN   = 4'd1;
	localparam mode_t MODE_SDCLOSED = 4'd2;
	localparam mode_t MODE_PRECHG   = 4'd3;
	localparam mode_t MODE_PCDONE   = 4'd4;
	localparam mode_t MODE_DRIVE    = 4'd5;
	localparam mode_t MODE_CHARGE   = 4'd6;
	localparam mode_t MODE_SOFT     = 4'd7;
	localparam mode_t MODE_HARD     = 4'd8;

	typedef struct packed {
		logic [9:0]  step_ms;
		logic [15:0] startup_ms;
		logic [15:0] precharge_ms;
		logic [15:0] volt_delta_limit;
		logic [15:0] charge_fresh_ms;
		logic [15:0] charge_timeout_ms;
	} cps_cfg_t;

	localparam cps_cfg_t CFG_RESET = '{
		step_ms:           10'd100,
		startup_ms:        16'd2500,
		precharge_ms:      16'd5000,
		volt_delta_limit:  16'd10,
		charge_fresh_ms:   16'd1000,
		charge_timeout_ms: 16'd2500
	};

	typedef struct packed {
		logic               sd_loop_ok;
		logic               iso_fault;
		logic               iso_fault_held;
		logic               pack_fault_latched;
		logic               high_side_closed;
		logic               main_closed;
		logic               button_drive;
		logic               button_pause;
		logic               charge_requested;
		logic        [15:0] charger_age_ms;
		logic signed [15:0] volt_delta;
	} cps_item_t;

	typedef struct packed {
		mode_t mode_out;
		logic  main_close_cmd;
		logic  precharge_cmd;
		logic  balance_cmd;
		logic  fault_cmd;
	} cps_result_t;

	typedef struct packed {
		mode_t                active_mode;
		mode_t                wanted_mode;
		logic [TimerBits-1:0] startup_elapsed;
		logic [TimerBits-1:0] precharge_elapsed;
		logic                 precharge_running;
		logic                 fault_latch;
	} cps_state_t;

	localparam cps_state_t STATE_RESET = '{
		active_mode:       MODE_STARTUP,
		wanted_mode:       MODE_SDOPEN,
		startup_elapsed:   '0,
		precharge_elapsed: '0,
		precharge_running: 1'b0,
		fault_latch:       1'b0
	};

endpackage

[sv/cps_in_if.sv]
interface cps_in_if;
	import cps_pkg::*;

	logic               valid;
	logic               ready;
	logic               sd_loop_ok;
	logic               iso_fault;
	logic               iso_fault_held;
	logic               pack_fault_latched;
	logic               high_side_closed;
	logic               main_closed;
	logic               button_drive;
	logic               button_pause;
	logic               charge_requested;
	logic        [15:0] charger_age_ms;
	logic signed [15:0] volt_delta;

	modport source (
		output valid, sd_loop_ok, iso_fault, iso_fault_held, pack_fault_latched,
		output high_side_closed, main_closed, button_drive, button_pause, charge_requested,
		output charger_age_ms, volt_delta,
		input  ready
	);

	modport sink (
		input  valid, sd_loop_ok, iso_fault, iso_fault_held, pack_fault_latched,
		input  high_side_closed, main_closed, button_drive, button_pause, charge_requested,
		input  charger_age_ms, volt_delta,
		output ready
	);

endinterface

[sv/cps_out_if.sv]
interface cps_out_if;
	import cps_pkg::*;

	logic        valid;
	logic        ready;
	logic [3:0]  mode_out;
	logic        main_close_cmd;
	logic        precharge_cmd;
	logic        balance_cmd;
	logic        fault_cmd;

	modport source (
		output valid, mode_out, main_close_cmd, precharge_cmd, balance_cmd, fault_cmd,
		input  ready
	);

	modport sink (
		input  valid, mode_out, main_close_cmd, precharge_cmd, balance_cmd, fault_cmd,
		output ready
	);

endinterface

[sv/contactor_precharge_sequencer.sv]
// Channel   Direction  Handshake      Payload
// in_ch     sink       valid/ready    one control tick: shutdown, faults, feedback,
//                                     buttons, charger request and age, voltage delta
// out_ch    source     valid/ready    new vehicle state and contactor/balance/fault cmds
// cfg       write      cfg_we         cfg_index selects register, cfg_data is the value
//
// One result per tick. The tick is held in an input register; the step logic and
// mode state update fire when it moves into the output register, which holds the
// result. One tick is accepted every cycle unless the output stalls, which holds
// both stages; arst_n returns modes, timers, latch and registers to defaults.
module contactor_precharge_sequencer (
	input  logic                     clk,
	input  logic                     arst_n,
	cps_in_if.sink                   in_ch,
	cps_out_if.source                out_ch,
	input  logic                     cfg_we,
	input  logic [cps_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [cps_pkg::CfgDataW-1:0] cfg_data
);
	import cps_pkg::*;

	cps_cfg_t    cfg_q;
	cps_state_t  state_q;
	cps_state_t  state_next;
	cps_item_t   item_in;
	cps_item_t   item_s1;
	logic        valid_s1;
	cps_result_t res_next;
	cps_result_t res_q;
	logic        out_valid_q;
	logic        advance;

	// Stage 1 moves forward when the output register is free or drains
	assign advance     = valid_s1 & (~out_valid_q | out_ch.ready);
	assign in_ch.ready = ~valid_s1 | advance;

	assign item_in.sd_loop_ok         = in_ch.sd_loop_ok;
	assign item_in.iso_fault          = in_ch.iso_fault;
	assign item_in.iso_fault_held     = in_ch.iso_fault_held;
	assign item_in.pack_fault_latched = in_ch.pack_fault_latched;
	assign item_in.high_side_closed   = in_ch.high_side_closed;
	assign item_in.main_closed        = in_ch.main_closed;
	assign item_in.button_drive       = in_ch.button_drive;
	assign item_in.button_pause       = in_ch.button_pause;
	assign item_in.charge_requested   = in_ch.charge_requested;
	assign item_in.charger_age_ms     = in_ch.charger_age_ms;
	assign item_in.volt_delta         = in_ch.volt_delta;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_STEP_MS:           cfg_q.step_ms           <= cfg_data[9:0];
				REG_STARTUP_MS:        cfg_q.startup_ms        <= cfg_data;
				REG_PRECHARGE_MS:      cfg_q.precharge_ms      <= cfg_data;
				REG_VOLT_DELTA_LIMIT:  cfg_q.volt_delta_limit  <= cfg_data;
				REG_CHARGE_FRESH_MS:   cfg_q.charge_fresh_ms   <= cfg_data;
				REG_CHARGE_TIMEOUT_MS: cfg_q.charge_timeout_ms <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready)
			item_s1 <= item_in;
	end

	cps_step u_step (
		.cfg  (cfg_q),
		.cur  (state_q),
		.item (item_s1),
		.nxt  (state_next),
		.res  (res_next)
	);

	// Mode state commits as the tick transfers to the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= STATE_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (advance)
				state_q <= state_next;
			if (advance)
				out_valid_q <= 1'b1;
			else if (out_ch.ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			res_q <= res_next;
	end

	assign out_ch.valid          = out_valid_q;
	assign out_ch.mode_out       = res_q.mode_out;
	assign out_ch.main_close_cmd = res_q.main_close_cmd;
	assign out_ch.precharge_cmd  = res_q.precharge_cmd;
	assign out_ch.balance_cmd    = res_q.balance_cmd;
	assign out_ch.fault_cmd      = res_q.fault_cmd;

endmodule

[sv/cps_step.sv]
module cps_step (
	input  cps_pkg::cps_cfg_t    cfg,
	input  cps_pkg::cps_state_t  cur,
	input  cps_pkg::cps_item_t   item,
	output cps_pkg::cps_state_t  nxt,
	output cps_pkg::cps_result_t res
);
	import cps_pkg::*;

	// Saturating timer advance by one tick
	function automatic logic [TimerBits-1:0] timer_add(
		input logic [TimerBits-1:0] t,
		input logic [9:0]           step
	);
		logic [TimerBits:0] sum;
		begin
			sum = {1'b0, t} + (TimerBits+1)'(step);
			return sum[TimerBits] ? '1 : sum[TimerBits-1:0];
		end
	endfunction

	logic        hard;
	logic [16:0] mag;
	logic        fresh;
	logic        timed_out;
	logic        startup_done;
	logic        precharge_done;
	mode_t       start;
	mode_t       wanted;
	mode_t       next_mode;
	logic        running;
	logic [TimerBits-1:0] pc_elapsed;
	logic        fault;
	logic        mcmd;
	logic        pcmd;
	logic        bal;

	assign start = cur.active_mode;
	assign hard  = item.iso_fault | item.iso_fault_held | item.pack_fault_latched;

	// Magnitude of the voltage delta, full negative value gives 32768
	assign mag = item.volt_delta[15] ? (17'h10000 - {1'b0, item.volt_delta})
	                                 : {1'b0, item.volt_delta};

	assign fresh        = item.charger_age_ms < cfg.charge_fresh_ms;
	assign timed_out    = item.charger_age_ms > cfg.charge_timeout_ms;
	assign startup_done = CmpW'(cur.startup_elapsed) > CmpW'(cfg.startup_ms);

	// Timer as seen in the precharge check: restarts on the first wish tick
	assign precharge_done = CmpW'(cur.precharge_running ? cur.precharge_elapsed : '0)
	                        > CmpW'(cfg.precharge_ms);

	// Wanted mode, then mode transition
	always_comb begin
		wanted     = cur.wanted_mode;
		next_mode  = start;
		running    = cur.precharge_running;
		pc_elapsed = cur.precharge_elapsed;
		fault      = cur.fault_latch;
		mcmd       = 1'b0;
		pcmd       = 1'b0;
		bal        = 1'b0;

		priority if (!item.sd_loop_ok) begin
			wanted = MODE_SDOPEN;
		end else if (item.charge_requested && fresh) begin
			wanted = MODE_CHARGE;
		end else if (item.button_drive) begin
			wanted = MODE_DRIVE;
		end else if (item.button_pause && start == MODE_DRIVE) begin
			wanted = MODE_PCDONE;
		end else begin
			// no new wish: keep the previous one
			wanted = cur.wanted_mode;
		end

		unique case (start)
			MODE_STARTUP: begin
				if (startup_done)
					next_mode = MODE_SDOPEN;
			end
			MODE_SDOPEN: begin
				wanted = MODE_SDOPEN;
				if (hard)
					next_mode = MODE_HARD;
				else if (item.sd_loop_ok)
					next_mode = MODE_SDCLOSED;
			end
			MODE_SDCLOSED: begin
				if (hard)
					next_mode = MODE_HARD;
				else if (!item.sd_loop_ok)
					next_mode = MODE_SDOPEN;
				else if (wanted == MODE_DRIVE || wanted == MODE_CHARGE)
					next_mode = MODE_PRECHG;
			end
			MODE_PRECHG: begin
				pcmd = 1'b1;
				if (hard) begin
					next_mode = MODE_HARD;
				end else if (!item.sd_loop_ok) begin
					next_mode = MODE_SDOPEN;
				end else if (wanted == MODE_DRIVE || wanted == MODE_CHARGE) begin
					if (!cur.precharge_running) begin
						running    = 1'b1;
						pc_elapsed = '0;
					end
					if (precharge_done) begin
						if (wanted == MODE_CHARGE)
							next_mode = MODE_CHARGE;
						else if (mag < {1'b0, cfg.volt_delta_limit})
							next_mode = MODE_DRIVE;
					end
				end else begin
					next_mode = MODE_SDCLOSED;
				end
			end
			MODE_PCDONE: begin
				mcmd = 1'b1;
				pcmd = 1'b1;
				if (hard)
					next_mode = MODE_HARD;
				else if (!item.sd_loop_ok)
					next_mode = MODE_SDOPEN;
				else if (!item.main_closed || !item.high_side_closed)
					next_mode = MODE_SDCLOSED;
				else if (wanted == MODE_DRIVE)
					next_mode = MODE_DRIVE;
			end
			MODE_DRIVE: begin
				mcmd = 1'b1;
				pcmd = 1'b1;
				if (hard)
					next_mode = MODE_HARD;
				else if (!item.sd_loop_ok)
					next_mode = MODE_SDOPEN;
			end
			MODE_CHARGE: begin
				mcmd = 1'b1;
				pcmd = 1'b1;
				bal  = 1'b1;
				if (wanted == MODE_SDOPEN) begin
					next_mode = MODE_SDOPEN;
				end else if (timed_out || wanted != MODE_CHARGE) begin
					next_mode = item.sd_loop_ok ? MODE_SDCLOSED : MODE_SDOPEN;
					wanted    = MODE_SDOPEN;
				end
			end
			MODE_SOFT: begin
			end
			// hard fault and unused codes latch the fault output
			default: begin
				fault = 1'b1;
			end
		endcase

		// Precharge timer runs only while staying in precharging
		if (next_mode != MODE_PRECHG) begin
			running    = 1'b0;
			pc_elapsed = '0;
		end else if (running) begin
			pc_elapsed = timer_add(pc_elapsed, cfg.step_ms);
		end
	end

	assign nxt.active_mode       = next_mode;
	assign nxt.wanted_mode       = wanted;
	assign nxt.startup_elapsed   = timer_add(cur.startup_elapsed, cfg.step_ms);
	assign nxt.precharge_elapsed = pc_elapsed;
	assign nxt.precharge_running = running;
	assign nxt.fault_latch       = fault;

	assign res.mode_out       = next_mode;
	assign res.main_close_cmd = mcmd;
	assign res.precharge_cmd  = pcmd;
	assign res.balance_cmd    = bal;
	assign res.fault_cmd      = fault;

endmodule

[tb/contactor_precharge_sequencer_test.sv]
`timescale 1ns / 1ps

module contactor_precharge_sequencer_test;
	import cps_pkg::*;

	localparam int HOLD_OFF_CYCLES = 60;
	localparam int WATCHDOG_LIMIT  = 2000;

	// Indexes past the last register; writes there must change nothing
	localparam cfg_idx_t REG_SPARE_LO = 3'd6;
	localparam cfg_idx_t REG_SPARE_HI = 3'd7;

	// Shape of the random stream for a run of ticks
	typedef enum int {AIM_NOISE, AIM_DRIVE, AIM_CHARGE, AIM_CHURN} aim_t;

	// Tracks the sequencer state per accepted tick and holds the commands it must emit
	class contactor_ledger;
		cps_cfg_t             cfg;
		mode_t                mode;
		mode_t                wish;
		logic [TimerBits-1:0] boot_timer;
		logic [TimerBits-1:0] precharge_timer;
		logic                 precharge_on;
		logic                 fault_seen;
		cps_result_t          expected_cmds[$];
		int                   errors;

		function new();
			cfg             = CFG_RESET;
			mode            = MODE_STARTUP;
			wish            = MODE_SDOPEN;
			boot_timer      = '0;
			precharge_timer = '0;
			precharge_on    = 1'b0;
			fault_seen      = 1'b0;
			errors          = 0;
		endfunction

		function void set_reg(cfg_idx_t idx, logic [15:0] val);
			case (idx)
				REG_STEP_MS:           cfg.step_ms = val[9:0];
				REG_STARTUP_MS:        cfg.startup_ms = val;
				REG_PRECHARGE_MS:      cfg.precharge_ms = val;
				REG_VOLT_DELTA_LIMIT:  cfg.volt_delta_limit = val;
				REG_CHARGE_FRESH_MS:   cfg.charge_fresh_ms = val;
				REG_CHARGE_TIMEOUT_MS: cfg.charge_timeout_ms = val;
				default: ;
			endcase
		endfunction

		// Saturating tick of a timer
		function logic [TimerBits-1:0] tick_timer(logic [TimerBits-1:0] t);
			logic [TimerBits:0] s;
			s = {1'b0, t} + cfg.step_ms;
			return s[TimerBits] ? {TimerBits{1'b1}} : s[TimerBits-1:0];
		endfunction

		function cps_result_t step_contactors(cps_item_t t);
			mode_t       start;
			mode_t       next;
			logic        trip;
			logic [16:0] mag;
			cps_result_t r;
			r     = '0;
			start = mode;
			next  = start;
			trip  = t.iso_fault | t.iso_fault_held | t.pack_fault_latched;
			mag   = t.volt_delta[15] ? (17'h10000 - {1'b0, t.volt_delta}) : {1'b0, t.volt_delta};

			// desired mode from the loop, a fresh charger request and the buttons
			if (!t.sd_loop_ok) begin
				wish = MODE_SDOPEN;
			end else if (t.charge_requested && t.charger_age_ms < cfg.charge_fresh_ms) begin
				wish = MODE_CHARGE;
			end else if (t.button_drive) begin
				wish = MODE_DRIVE;
			end else if (t.button_pause && start == MODE_DRIVE) begin
				wish = MODE_PCDONE;
			end

			case (start)
				MODE_STARTUP: begin
					if (boot_timer > cfg.startup_ms)
						next = MODE_SDOPEN;
				end
				MODE_SDOPEN: begin
					wish = MODE_SDOPEN;
					if (trip)
						next = MODE_HARD;
					else if (t.sd_loop_ok)
						next = MODE_SDCLOSED;
				end
				MODE_SDCLOSED: begin
					if (trip)
						next = MODE_HARD;
					else if (!t.sd_loop_ok)
						next = MODE_SDOPEN;
					else if (wish == MODE_DRIVE || wish == MODE_CHARGE)
						next = MODE_PRECHG;
				end
				MODE_PRECHG: begin
					r.precharge_cmd = 1'b1;
					if (trip) begin
						next = MODE_HARD;
					end else if (!t.sd_loop_ok) begin
						next = MODE_SDOPEN;
					end else if (wish == MODE_DRIVE || wish == MODE_CHARGE) begin
						// timer restarts on the first tick that wants to run
						if (!precharge_on) begin
							precharge_on    = 1'b1;
							precharge_timer = '0;
						end
						if (precharge_timer > cfg.precharge_ms) begin
							if (wish == MODE_CHARGE)
								next = MODE_CHARGE;
							else if (mag < cfg.volt_delta_limit)
								next = MODE_DRIVE;
						end
					end else begin
						next = MODE_SDCLOSED;
					end
				end
				MODE_PCDONE: begin
					r.main_close_cmd = 1'b1;
					r.precharge_cmd  = 1'b1;
					if (trip)
						next = MODE_HARD;
					else if (!t.sd_loop_ok)
						next = MODE_SDOPEN;
					else if (!t.main_closed || !t.high_side_closed)
						next = MODE_SDCLOSED;
					else if (wish == MODE_DRIVE)
						next = MODE_DRIVE;
				end
				MODE_DRIVE: begin
					r.main_close_cmd = 1'b1;
					r.precharge_cmd  = 1'b1;
					if (trip)
						next = MODE_HARD;
					else if (!t.sd_loop_ok)
						next = MODE_SDOPEN;
				end
				MODE_CHARGE: begin
					// no fault checks while charging
					r.main_close_cmd = 1'b1;
					r.precharge_cmd  = 1'b1;
					r.balance_cmd    = 1'b1;
					if (wish == MODE_SDOPEN) begin
						next = MODE_SDOPEN;
					end else if (t.charger_age_ms > cfg.charge_timeout_ms || wish != MODE_CHARGE) begin
						next = t.sd_loop_ok ? MODE_SDCLOSED : MODE_SDOPEN;
						wish = MODE_SDOPEN;
					end
				end
				MODE_SOFT: ;
				default: fault_seen = 1'b1;
			endcase

			mode = next;
			if (mode != MODE_PRECHG) begin
				precharge_on    = 1'b0;
				precharge_timer = '0;
			end else if (precharge_on) begin
				precharge_timer = tick_timer(precharge_timer);
			end
			boot_timer = tick_timer(boot_timer);

			r.mode_out  = mode;
			r.fault_cmd = fault_seen;
			return r;
		endfunction

		function void note_tick(cps_item_t t);
			expected_cmds.push_back(step_contactors(t));
		endfunction

		function int pending();
			return expected_cmds.size();
		endfunction

		function void compare_field(string field, int unsigned want, int unsigned got);
			if (want != got) begin
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
				errors++;
			end
		endfunction

		function void check_result(cps_result_t got);
			cps_result_t want;
			if (expected_cmds.size() == 0) begin
				$display("%0t: result with no tick outstanding, expected none, actual %h",
					$time, got);
				errors++;
				return;
			end
			want = expected_cmds.pop_front();
			compare_field("mode_out", want.mode_out, got.mode_out);
			compare_field("main_close_cmd", want.main_close_cmd, got.main_close_cmd);
			compare_field("precharge_cmd", want.precharge_cmd, got.precharge_cmd);
			compare_field("balance_cmd", want.balance_cmd, got.balance_cmd);
			compare_field("fault_cmd", want.fault_cmd, got.fault_cmd);
		endfunction
	endclass

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	cfg_idx_t         cfg_index;
	logic [CfgDataW-1:0] cfg_data;

	cps_in_if  in_ch();
	cps_out_if out_ch();

	contactor_ledger ledger;
	aim_t aim         = AIM_NOISE;
	int   aim_left    = 0;
	bit   quiet       = 1'b0;
	bit   hold_off    = 1'b0;
	bit   fault_armed = 1'b0;

	contactor_precharge_sequencer u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic drive_payload(input cps_item_t it);
		in_ch.sd_loop_ok         <= it.sd_loop_ok;
		in_ch.iso_fault          <= it.iso_fault;
		in_ch.iso_fault_held     <= it.iso_fault_held;
		in_ch.pack_fault_latched <= it.pack_fault_latched;
		in_ch.high_side_closed   <= it.high_side_closed;
		in_ch.main_closed        <= it.main_closed;
		in_ch.button_drive       <= it.button_drive;
		in_ch.button_pause       <= it.button_pause;
		in_ch.charge_requested   <= it.charge_requested;
		in_ch.charger_age_ms     <= it.charger_age_ms;
		in_ch.volt_delta         <= it.volt_delta;
	endtask

	function automatic cps_item_t compose_tick(logic sd, logic [2:0] faults, logic [1:0] feedback,
			logic [1:0] buttons, logic chreq, logic [15:0] age, logic [15:0] delta);
		return {sd, faults, feedback, buttons, chreq, age, delta};
	endfunction

	// Random tick shaped by the current aim and the mode the ledger is in
	function automatic cps_item_t make_tick();
		cps_item_t   it;
		logic [63:0] bits;
		logic [15:0] mag16;
		int unsigned lim;
		int unsigned fresh;
		int unsigned tmo;
		int unsigned pick;
		mode_t       now;
		now   = ledger.mode;
		fresh = ledger.cfg.charge_fresh_ms;
		tmo   = ledger.cfg.charge_timeout_ms;
		lim   = ledger.cfg.volt_delta_limit;
		bits  = {$urandom, $urandom};
		it    = bits[$bits(cps_item_t)-1:0];

		if (aim_left == 0) begin
			pick     = $urandom_range(0, 19);
			aim      = aim_t'((pick < 3) ? AIM_NOISE : (pick < 11) ? AIM_DRIVE :
				(pick < 18) ? AIM_CHARGE : AIM_CHURN);
			aim_left = $urandom_range(20, 120);
		end
		aim_left--;

		case (aim)
			AIM_DRIVE, AIM_CHARGE: begin
				it.sd_loop_ok   = ($urandom_range(0, 79) != 0);
				it.button_pause = ($urandom_range(0, 3) == 0);
				if (aim == AIM_DRIVE) begin
					it.button_drive     = ($urandom_range(0, 9) != 0);
					it.charge_requested = ($urandom_range(0, 9) == 0);
				end else begin
					it.button_drive     = ($urandom_range(0, 19) == 0);
					it.charge_requested = ($urandom_range(0, 9) != 0);
					pick = $urandom_range(0, 29);
					if (pick == 0) begin
						// charger went quiet
						it.charger_age_ms = (tmo < 16'hFFFF) ?
							16'($urandom_range(tmo + 1, 16'hFFFF)) : 16'hFFFF;
					end else if (pick == 1) begin
						case ($urandom_range(0, 3))
							0: it.charger_age_ms = 16'(fresh);
							1: it.charger_age_ms = 16'(fresh - 1);
							2: it.charger_age_ms = 16'(tmo);
							default: it.charger_age_ms = 16'(tmo + 1);
						endcase
					end else if (fresh > 0) begin
						it.charger_age_ms = 16'($urandom_range(0, fresh - 1));
					end
				end
				// mostly a delta small enough to close for drive, sometimes on the limit
				pick = $urandom_range(0, 9);
				if (pick < 8) begin
					mag16 = 16'((pick == 0) ? lim : $urandom_range(0, (lim > 0) ? lim - 1 : 0));
					it.volt_delta = ($urandom_range(0, 1) != 0) ? -mag16 : mag16;
				end
			end
			AIM_CHURN: begin
				it.button_drive     = 1'b0;
				it.button_pause     = 1'b0;
				it.charge_requested = 1'b0;
			end
			default: ;
		endcase

		// faults are only free where the block ignores them; one is injected when armed
		if (now != MODE_STARTUP && now != MODE_CHARGE && now < MODE_HARD) begin
			it.iso_fault          = 1'b0;
			it.iso_fault_held     = 1'b0;
			it.pack_fault_latched = 1'b0;
			if (fault_armed && (now == MODE_DRIVE || $urandom_range(0, 49) == 0)) begin
				case ($urandom_range(0, 2))
					0: it.iso_fault = 1'b1;
					1: it.iso_fault_held = 1'b1;
					default: it.pack_fault_latched = 1'b1;
				endcase
				fault_armed = 1'b0;
			end
		end
		return it;
	endfunction

	// Offer one tick and wait for its transfer
	task automatic send_tick(input cps_item_t it);
		if (!quiet && $urandom_range(0, 4) == 0) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		drive_payload(it);
		in_ch.valid <= 1'b1;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		ledger.note_tick(it);
	endtask

	task automatic run_ticks(input int count);
		repeat (count) send_tick(make_tick());
	endtask

	// Stop offering and wait until every expected result has come back
	task automatic wait_idle();
		in_ch.valid <= 1'b0;
		while (ledger.pending() != 0) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [15:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		ledger.set_reg(idx, val);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic apply_profile(input logic [15:0] step, input logic [15:0] boot,
			input logic [15:0] prechg, input logic [15:0] vlim, input logic [15:0] fresh,
			input logic [15:0] tmo);
		write_reg(REG_STEP_MS, step);
		write_reg(REG_STARTUP_MS, boot);
		write_reg(REG_PRECHARGE_MS, prechg);
		write_reg(REG_VOLT_DELTA_LIMIT, vlim);
		write_reg(REG_CHARGE_FRESH_MS, fresh);
		write_reg(REG_CHARGE_TIMEOUT_MS, tmo);
	endtask

	// Result side: check each transfer, stall in bursts, honor a long hold-off
	initial begin
		int stall;
		stall = 0;
		out_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (out_ch.valid && out_ch.ready)
				ledger.check_result({out_ch.mode_out, out_ch.main_close_cmd,
					out_ch.precharge_cmd, out_ch.balance_cmd, out_ch.fault_cmd});
			if (hold_off) begin
				out_ch.ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
				hold_off = 1'b0;
				out_ch.ready <= 1'b1;
			end else if (stall > 0) begin
				out_ch.ready <= 1'b0;
				stall--;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				out_ch.ready <= 1'b0;
				stall = $urandom_range(1, 8) - 1;
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	// Watchdog: too long without any transfer ends the run
	initial begin
		int quiet_cycles;
		quiet_cycles = 0;
		forever begin
			@(posedge clk);
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("contactor_precharge_sequencer regression: fail");
				$finish;
			end
		end
	end

	initial begin
		ledger = new();
		arst_n    <= 1'b0;
		cfg_we    <= 1'b0;
		cfg_index <= REG_STEP_MS;
		cfg_data  <= '0;
		in_ch.valid <= 1'b0;
		drive_payload('0);
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed ticks while still in startup: field extremes, fresh-age edge, each fault
		send_tick(compose_tick(1'b0, 3'b000, 2'b00, 2'b00, 1'b0, 16'h0000, 16'h0000));
		send_tick(compose_tick(1'b1, 3'b111, 2'b11, 2'b11, 1'b1, 16'hFFFF, 16'h8000));
		send_tick(compose_tick(1'b1, 3'b000, 2'b00, 2'b00, 1'b1, 16'h0000, 16'h7FFF));
		send_tick(compose_tick(1'b0, 3'b100, 2'b10, 2'b10, 1'b0, 16'h0001, 16'hFFFF));
		send_tick(compose_tick(1'b1, 3'b010, 2'b01, 2'b01, 1'b1, 16'd999, 16'd9));
		send_tick(compose_tick(1'b1, 3'b001, 2'b00, 2'b10, 1'b1, 16'd1000, 16'hFFF6));
		send_tick(compose_tick(1'b1, 3'b000, 2'b11, 2'b01, 1'b0, 16'h8000, 16'd10));
		send_tick(compose_tick(1'b1, 3'b000, 2'b00, 2'b10, 1'b0, 16'd2500, 16'hFFF7));
		send_tick(compose_tick(1'b0, 3'b111, 2'b00, 2'b00, 1'b1, 16'd2501, 16'h0001));
		send_tick(compose_tick(1'b1, 3'b000, 2'b01, 2'b00, 1'b1, 16'h7FFF, 16'h8001));
		send_tick(compose_tick(1'b1, 3'b000, 2'b10, 2'b11, 1'b0, 16'h00FF, 16'h000B));
		send_tick(compose_tick(1'b1, 3'b000, 2'b00, 2'b10, 1'b0, 16'hFFFE, 16'h0000));
		run_ticks(8);
		wait_idle();

		// Startup wait past the timer ceiling: never leaves startup
		write_reg(REG_STEP_MS, 16'd1000);
		write_reg(REG_STARTUP_MS, 16'hFFFF);
		run_ticks(80);
		wait_idle();

		// Reset values again; long output stall partway through
		apply_profile(16'd100, 16'd2500, 16'd5000, 16'd10, 16'd1000, 16'd2500);
		run_ticks(100);
		hold_off = 1'b1;
		run_ticks(300);
		wait_idle();

		// Fast profile, wide-open limits; spare indexes must be ignored
		write_reg(REG_SPARE_LO, 16'hFFFF);
		write_reg(REG_SPARE_HI, 16'hFFFF);
		apply_profile(16'd1000, 16'd0, 16'd0, 16'd32768, 16'hFFFF, 16'hFFFF);
		run_ticks(200);
		wait_idle();

		// Slow timer, tight delta, charger never fresh and timed out at every nonzero age
		apply_profile(16'd1, 16'd0, 16'd30, 16'd1, 16'd0, 16'd0);
		run_ticks(200);
		wait_idle();

		// Zero step freezes the timers: precharge cannot finish
		apply_profile(16'd0, 16'd0, 16'd0, 16'd500, 16'd700, 16'd900);
		run_ticks(100);
		wait_idle();

		// Precharge limit at the ceiling and zero delta limit
		apply_profile(16'd1000, 16'd1234, 16'hFFFF, 16'd0, 16'd3000, 16'd5000);
		run_ticks(120);
		wait_idle();

		// Last part without idling, ending in a sticky hard fault
		apply_profile(16'd250, 16'd0, 16'd1000, 16'd500, 16'd2000, 16'd3000);
		quiet = 1'b1;
		run_ticks(300);
		fault_armed = 1'b1;
		run_ticks(150);
		wait_idle();

		repeat (10) @(posedge clk);
		if (ledger.errors == 0 && ledger.pending() == 0)
			$display("contactor_precharge_sequencer regression: pass");
		else
			$display("contactor_precharge_sequencer regression: fail");
		$finish;
	end

endmodule

[files.f]
sv/cps_pkg.sv
sv/cps_in_if.sv
sv/cps_out_if.sv
sv/cps_step.sv
sv/contactor_precharge_sequencer.sv
tb/contactor_precharge_sequencer_test.sv
